[hw/rtl/dmph_pkg.sv]
package dmph_pkg;

  localparam int unsigned MaxLen = 1024;
  localparam int unsigned LenW   = 11;
  localparam int unsigned IdxW   = $clog2(MaxLen);
  localparam int unsigned WordW  = 30;
  localparam int unsigned TagW   = 2;

  localparam logic [WordW-1:0] ModA = 30'd1000000007;
  localparam logic [WordW-1:0] ModB = 30'd1000000009;

  // barrett constants floor(2^60 / m)
  localparam logic [WordW:0] MuA = 31'((64'd1 << 60) / 64'(ModA));
  localparam logic [WordW:0] MuB = 31'((64'd1 << 60) / 64'(ModB));

  localparam logic [WordW-1:0] BaseReset = 30'd263;

  typedef enum logic [1:0] {
    OpAppend = 2'd0,
    OpQuery  = 2'd1,
    OpClear  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StRange    = 2'd1,
    StOverflow = 2'd2
  } status_e;

  // multiplier job tags
  localparam logic [TagW-1:0] TagHashA = 2'd0;
  localparam logic [TagW-1:0] TagHashB = 2'd1;
  localparam logic [TagW-1:0] TagPowA  = 2'd2;
  localparam logic [TagW-1:0] TagPowB  = 2'd3;
  localparam logic [TagW-1:0] TagSubA  = 2'd0;
  localparam logic [TagW-1:0] TagSubB  = 2'd1;

  typedef struct packed {
    logic [WordW-1:0] second;
    logic [WordW-1:0] first;
  } pair_t;

  localparam pair_t HashInit = '{second: 30'd0, first: 30'd0};
  localparam pair_t PowInit  = '{second: 30'd1, first: 30'd1};

  typedef struct packed {
    logic [WordW-1:0] mul_a;
    logic [WordW-1:0] mul_b;
    logic [7:0]       addend;
    logic             sel_b;
    logic [TagW-1:0]  tag;
  } mm_req_t;

  typedef struct packed {
    logic [WordW-1:0] value;
    logic [TagW-1:0]  tag;
  } mm_rsp_t;

  function automatic logic [WordW-1:0] mod_of(input logic sel_b);
    return sel_b ? ModB : ModA;
  endfunction

endpackage

[hw/rtl/double_mod_prefix_hash_unit.sv]
// append: no result; the input stalls until the prefix entry is written and the unit is idle again
// query: result registered after the multiplier jobs and the subtraction; the input stalls until it is loaded out
// append overflow or query range error: result registered without multiplier jobs; clear: length reset in idle
// appends and queries use the 5-stage shared modular multiplier (4 jobs per append, 2 per query)
// reset is asynchronous: length 0, base 263, no memory sweep since entry zero is a constant
module double_mod_prefix_hash_unit import dmph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       operation_i,
  input  logic [7:0]       char_byte_i,
  input  logic [LenW-1:0]  span_start_i,
  input  logic [LenW-1:0]  span_end_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] hash_first_o,
  output logic [WordW-1:0] hash_second_o,
  output logic [1:0]       status_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WordW-1:0] cfg_hash_base_i
);

  typedef enum logic [4:0] {
    SIdle   = 5'b00001,
    SIssue  = 5'b00010,
    SWait   = 5'b00100,
    SFinish = 5'b01000,
    SEmit   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [TagW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] base_q;
  op_e              op_q, in_op;
  logic [7:0]       byte_q;
  logic [WordW-1:0] res_q [4];

  logic [WordW-1:0] pend_hf_q, pend_hf_d, pend_hs_q, pend_hs_d;
  status_e          pend_st_q, pend_st_d;

  logic             out_valid_q;
  logic [WordW-1:0] out_hf_q, out_hs_q;
  status_e          out_st_q;

  logic            in_acc, full, span_bad, out_free, out_load, wr_en;
  logic [TagW-1:0] last_tag;
  logic [LenW-1:0] hash_a_addr, pow_addr;
  pair_t           hash_a, hash_b, pow;
  logic            req_valid, rsp_valid;
  mm_req_t         req;
  mm_rsp_t         rsp;

  function automatic logic [WordW-1:0] sub_mod(input logic [WordW-1:0] h,
                                               input logic [WordW-1:0] t,
                                               input logic sel_b);
    logic [WordW:0] m;
    logic [WordW:0] d;
    m = {1'b0, mod_of(sel_b)};
    d = {1'b0, h} + m - {1'b0, t};
    return (d >= m) ? WordW'(d - m) : WordW'(d);
  endfunction

  assign in_op      = op_e'(operation_i);
  assign in_acc     = in_valid_i && (state_q == SIdle);
  assign in_stall_o = (state_q != SIdle);
  assign full       = (len_q == LenW'(MaxLen));
  assign span_bad   = (span_start_i > span_end_i) || (span_end_i > len_q);
  assign last_tag   = (op_q == OpAppend) ? TagPowB : TagSubB;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == SEmit) && out_free;
  assign cfg_ready_o = 1'b1;

  assign hash_a_addr = (in_op == OpQuery) ? span_start_i : len_q;
  assign pow_addr    = (in_op == OpQuery) ? (span_end_i - span_start_i) : len_q;

  dmph_store u_store (
    .clk_i         (clk_i),
    .rd_en_i       (in_acc),
    .hash_a_addr_i (hash_a_addr),
    .hash_b_addr_i (span_end_i),
    .pow_addr_i    (pow_addr),
    .hash_a_o      (hash_a),
    .hash_b_o      (hash_b),
    .pow_o         (pow),
    .wr_en_i       (wr_en),
    .wr_idx_i      (len_q[IdxW-1:0]),
    .wr_hash_i     ('{second: res_q[TagHashB], first: res_q[TagHashA]}),
    .wr_pow_i      ('{second: res_q[TagPowB], first: res_q[TagPowA]})
  );

  // job selection for the shared multiplier
  assign req_valid = (state_q == SIssue);

  always_comb begin
    req.mul_a  = base_q;
    req.mul_b  = hash_a.first;
    req.addend = byte_q;
    req.sel_b  = 1'b0;
    req.tag    = cnt_q;
    if (op_q == OpAppend) begin
      unique case (cnt_q)
        TagHashA: begin
          req.mul_b = hash_a.first;
        end
        TagHashB: begin
          req.mul_b = hash_a.second;
          req.sel_b = 1'b1;
        end
        TagPowA: begin
          req.mul_b  = pow.first;
          req.addend = '0;
        end
        TagPowB: begin
          req.mul_b  = pow.second;
          req.addend = '0;
          req.sel_b  = 1'b1;
        end
      endcase
    end else begin
      // h[start] * p[end - start]
      req.addend = '0;
      if (cnt_q == TagSubB) begin
        req.mul_a = hash_a.second;
        req.mul_b = pow.second;
        req.sel_b = 1'b1;
      end else begin
        req.mul_a = hash_a.first;
        req.mul_b = pow.first;
      end
    end
  end

  dmph_modmul u_modmul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    wr_en     = 1'b0;
    pend_hf_d = pend_hf_q;
    pend_hs_d = pend_hs_q;
    pend_st_d = pend_st_q;
    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          cnt_d = '0;
          unique case (in_op)
            OpAppend: begin
              if (full) begin
                pend_hf_d = '0;
                pend_hs_d = '0;
                pend_st_d = StOverflow;
                state_d   = SEmit;
              end else begin
                state_d = SIssue;
              end
            end
            OpQuery: begin
              if (span_bad) begin
                pend_hf_d = '0;
                pend_hs_d = '0;
                pend_st_d = StRange;
                state_d   = SEmit;
              end else begin
                state_d = SIssue;
              end
            end
            OpClear: begin
              len_d = '0;
            end
            default: ;
          endcase
        end
      end
      SIssue: begin
        cnt_d = cnt_q + TagW'(1);
        if (cnt_q == last_tag) begin
          state_d = SWait;
        end
      end
      SWait: begin
        if (rsp_valid && (rsp.tag == last_tag)) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        if (op_q == OpAppend) begin
          wr_en   = 1'b1;
          len_d   = len_q + LenW'(1);
          state_d = SIdle;
        end else begin
          pend_hf_d = sub_mod(hash_b.first, res_q[TagSubA], 1'b0);
          pend_hs_d = sub_mod(hash_b.second, res_q[TagSubB], 1'b1);
          pend_st_d = StOk;
          state_d   = SEmit;
        end
      end
      SEmit: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      len_q       <= '0;
      cnt_q       <= '0;
      base_q      <= BaseReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_hash_base_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_hf_q <= pend_hf_d;
    pend_hs_q <= pend_hs_d;
    pend_st_q <= pend_st_d;
    if (in_acc) begin
      op_q   <= in_op;
      byte_q <= char_byte_i;
    end
    if (rsp_valid) begin
      res_q[rsp.tag] <= rsp.value;
    end
    if (out_load) begin
      out_hf_q <= pend_hf_q;
      out_hs_q <= pend_hs_q;
      out_st_q <= pend_st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hash_first_o  = out_hf_q;
  assign hash_second_o = out_hs_q;
  assign status_o      = out_st_q;

endmodule

[hw/rtl/dmph_store.sv]
module dmph_store import dmph_pkg::*; (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [LenW-1:0] hash_a_addr_i,
  input  logic [LenW-1:0] hash_b_addr_i,
  input  logic [LenW-1:0] pow_addr_i,
  output pair_t           hash_a_o,
  output pair_t           hash_b_o,
  output pair_t           pow_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  pair_t           wr_hash_i,
  input  pair_t           wr_pow_i
);

  // prefix entry k lives at row k-1, entry zero is a constant
  pair_t hash_mem [MaxLen];
  pair_t pow_mem  [MaxLen];

  pair_t hash_a_q, hash_b_q, pow_q;
  logic  a_zero_q, b_zero_q, p_zero_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      hash_mem[wr_idx_i] <= wr_hash_i;
      pow_mem[wr_idx_i]  <= wr_pow_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      hash_a_q <= hash_mem[IdxW'(hash_a_addr_i - LenW'(1))];
      hash_b_q <= hash_mem[IdxW'(hash_b_addr_i - LenW'(1))];
      pow_q    <= pow_mem[IdxW'(pow_addr_i - LenW'(1))];
      a_zero_q <= (hash_a_addr_i == '0);
      b_zero_q <= (hash_b_addr_i == '0);
      p_zero_q <= (pow_addr_i == '0);
    end
  end

  assign hash_a_o = a_zero_q ? HashInit : hash_a_q;
  assign hash_b_o = b_zero_q ? HashInit : hash_b_q;
  assign pow_o    = p_zero_q ? PowInit : pow_q;

endmodule

[hw/rtl/dmph_modmul.sv]
module dmph_modmul import dmph_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  input  mm_req_t req_i,
  output logic    rsp_valid_o,
  output mm_rsp_t rsp_o
);

  // (a * b + addend) mod m, barrett reduction over five stages
  logic [4:0] vld_q;

  logic [59:0]     s1_prod_q;
  logic [7:0]      s1_add_q, s2_add_q, s3_add_q;
  logic            s1_sel_q, s2_sel_q, s3_sel_q, s4_sel_q;
  logic [TagW-1:0] s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q;

  logic [61:0] s2_prod_q;
  logic [31:0] s2_lo_q, s3_lo_q;
  logic [31:0] s3_qm_q;
  logic [31:0] s4_r_q;
  mm_rsp_t     s5_q;

  logic [WordW:0]   mu;
  logic [WordW:0]   quot;
  logic [60:0]      qm;
  logic [31:0]      m1, m2, m3, red;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], req_valid_i};
    end
  end

  assign mu   = s1_sel_q ? MuB : MuA;
  assign quot = s2_prod_q[61:31];
  assign qm   = 61'(quot) * 61'(mod_of(s2_sel_q));

  // remainder plus addend stays below four times the modulus
  assign m1 = 32'(mod_of(s4_sel_q));
  assign m2 = {m1[30:0], 1'b0};
  assign m3 = m1 + m2;

  always_comb begin
    priority if (s4_r_q >= m3) begin
      red = s4_r_q - m3;
    end else if (s4_r_q >= m2) begin
      red = s4_r_q - m2;
    end else if (s4_r_q >= m1) begin
      red = s4_r_q - m1;
    end else begin
      red = s4_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_prod_q <= 60'(req_i.mul_a) * 60'(req_i.mul_b);
    s1_add_q  <= req_i.addend;
    s1_sel_q  <= req_i.sel_b;
    s1_tag_q  <= req_i.tag;

    s2_prod_q <= 62'(s1_prod_q[59:29]) * 62'(mu);
    s2_lo_q   <= s1_prod_q[31:0];
    s2_add_q  <= s1_add_q;
    s2_sel_q  <= s1_sel_q;
    s2_tag_q  <= s1_tag_q;

    s3_qm_q  <= qm[31:0];
    s3_lo_q  <= s2_lo_q;
    s3_add_q <= s2_add_q;
    s3_sel_q <= s2_sel_q;
    s3_tag_q <= s2_tag_q;

    s4_r_q   <= s3_lo_q - s3_qm_q + 32'(s3_add_q);
    s4_sel_q <= s3_sel_q;
    s4_tag_q <= s3_tag_q;

    s5_q.value <= red[WordW-1:0];
    s5_q.tag   <= s4_tag_q;
  end

  assign rsp_valid_o = vld_q[4];
  assign rsp_o       = s5_q;

endmodule
